// ----- src/ihde_pkg.sv -----
`timescale 1ns / 1ps
package ihde_pkg;

   localparam int unsigned POSITION_BITS = 32;
   localparam int unsigned QUEUE_DEPTH   = 4;
   localparam int unsigned QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [31:0] MAX_EDGE_RESET = 32'd16384;
   localparam logic [31:0] CRC_POLY       = 32'hEDB88320;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UV    = 2'd1;
   localparam logic [1:0] ST_UNSUP = 2'd2;

   localparam logic [1:0] FMT_NONE = 2'd0;
   localparam logic [1:0] FMT_PNG  = 2'd1;
   localparam logic [1:0] FMT_JPEG = 2'd2;
   localparam logic [1:0] FMT_WEBP = 2'd3;

   localparam logic [4:0] PH_HEAD  = 5'd0;
   localparam logic [4:0] PH_DONE  = 5'd1;
   localparam logic [4:0] J_FF     = 5'd2;
   localparam logic [4:0] J_MARK   = 5'd3;
   localparam logic [4:0] J_LEN_HI = 5'd4;
   localparam logic [4:0] J_LEN_LO = 5'd5;
   localparam logic [4:0] J_SKIP   = 5'd6;
   localparam logic [4:0] J_FRAME  = 5'd7;
   localparam logic [4:0] J_TAIL   = 5'd8;
   localparam logic [4:0] W_HDR    = 5'd9;
   localparam logic [4:0] W_SKIP   = 5'd10;
   localparam logic [4:0] W_BODY   = 5'd11;
   localparam logic [4:0] W_PAD    = 5'd12;

   localparam logic [7:0] KIND_NONE = 8'd0;
   localparam logic [7:0] KIND_VP8  = 8'd1;
   localparam logic [7:0] KIND_VP8L = 8'd2;
   localparam logic [7:0] KIND_VP8X = 8'd3;

   localparam logic [15:0] ODD_FLAG      = 16'h0100;
   localparam logic [15:0] MISMATCH_FLAG = 16'h0200;

   localparam logic [7:0] PNG_SIG  [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                           8'h0D, 8'h0A, 8'h1A, 8'h0A};
   localparam logic [7:0] IHDR_TAG [4] = '{8'h49, 8'h48, 8'h44, 8'h52};
   localparam logic [7:0] RIFF_TAG [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
   localparam logic [7:0] WEBP_TAG [4] = '{8'h57, 8'h45, 8'h42, 8'h50};
   localparam logic [7:0] VP8_TAG  [3] = '{8'h56, 8'h50, 8'h38};

   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      logic       last_byte;
   } ihde_word_type;

   function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] x;
      x = c ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         x = (x >> 1) ^ (x[0] ? CRC_POLY : 32'h0);
      end
      return x;
   endfunction

   function automatic logic depth_fits(input logic [7:0] colour, input logic [7:0] depth);
      logic ok;
      case (colour)
         8'd0: ok = depth inside {8'd1, 8'd2, 8'd4, 8'd8, 8'd16};
         8'd3: ok = depth inside {8'd1, 8'd2, 8'd4, 8'd8};
         8'd2, 8'd4, 8'd6: ok = depth inside {8'd8, 8'd16};
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

// ----- src/ihde_req_if.sv -----
`timescale 1ns / 1ps
interface ihde_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- src/ihde_rsp_if.sv -----
`timescale 1ns / 1ps
interface ihde_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] img_width;
   logic [31:0] img_height;

   modport source (output valid, output status, output img_width, output img_height,
                   input ready);
   modport sink (input valid, input status, input img_width, input img_height,
                 output ready);
endinterface

// ----- src/image_header_dimension_extractor.sv -----
`timescale 1ns / 1ps
// Image header dimension extractor: feed the bytes of one PNG, JPEG or WebP file in
// order on req_chan, with last_byte on the final byte; one word (status, width, height)
// comes out on rsp_chan for every file. The last byte goes through a 4-word input queue
// and is parsed in the cycle it reaches the head; the result word is registered from
// that parse, so it shows only after both the queue entry and the result register.
// Bytes are taken at one per cycle while the queue has room; the parser consumes one
// queued byte per cycle, and stalls only when a file's last byte meets a result that
// has not yet been taken. The user must write max_edge through csr_write_enable /
// csr_write_data only while the block is idle; the block does not enforce it. Status
// 0 is ok, 1 unverifiable, 2 unsupported encoding; width and height are 0 if not ok.
module image_header_dimension_extractor (
   input  logic        clock,
   input  logic        reset,
   ihde_req_if.sink    req_chan,
   ihde_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   ihde_pkg::ihde_word_type head_word;
   logic head_pop;

   ihde_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_chan.valid),
      .in_ready     (req_chan.ready),
      .in_data_byte (req_chan.data_byte),
      .in_last_byte (req_chan.last_byte),
      .head_word    (head_word),
      .head_pop     (head_pop)
   );

   ihde_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .head_word        (head_word),
      .head_pop         (head_pop),
      .out_valid        (rsp_chan.valid),
      .out_ready        (rsp_chan.ready),
      .out_status       (rsp_chan.status),
      .out_width        (rsp_chan.img_width),
      .out_height       (rsp_chan.img_height)
   );

endmodule

// ----- src/ihde_front.sv -----
`timescale 1ns / 1ps
module ihde_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [7:0]            in_data_byte,
   input  logic                  in_last_byte,
   output ihde_pkg::ihde_word_type head_word,
   input  logic                  head_pop
);

   logic [8:0] queue_mem_ff [ihde_pkg::QUEUE_DEPTH];
   logic [ihde_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [ihde_pkg::QUEUE_PTR_BITS:0] count_ff, count_in;
   logic push, pop;

   assign in_ready = (count_ff != (ihde_pkg::QUEUE_PTR_BITS+1)'(ihde_pkg::QUEUE_DEPTH));
   assign push = in_valid && in_ready;
   assign pop  = head_pop && (count_ff != '0);

   assign head_word.valid     = (count_ff != '0);
   assign head_word.data_byte = queue_mem_ff[rd_ptr_ff][8:1];
   assign head_word.last_byte = queue_mem_ff[rd_ptr_ff][0];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + (push ? 1'b1 : 1'b0);
      rd_ptr_in = rd_ptr_ff + (pop ? 1'b1 : 1'b0);
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) queue_mem_ff[wr_ptr_ff] <= {in_data_byte, in_last_byte};
   end

endmodule

// ----- src/ihde_back.sv -----
`timescale 1ns / 1ps
module ihde_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [31:0]           csr_write_data,
   input  ihde_pkg::ihde_word_type head_word,
   output logic                  head_pop,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [1:0]            out_status,
   output logic [31:0]           out_width,
   output logic [31:0]           out_height
);

   localparam int unsigned PB = ihde_pkg::POSITION_BITS;

   logic [31:0]   max_edge_ff;
   logic [1:0]    fmt_ff, fmt_in;
   logic [4:0]    ph_ff, ph_in;
   logic [PB-1:0] pos_ff, pos_in;
   logic [32:0]   span_ff, span_in;
   logic [32:0]   riff_ff, riff_in;
   logic [31:0]   crc_ff, crc_in;
   logic [31:0]   fs_ff, fs_in;
   logic [31:0]   fw_ff, fw_in;
   logic [31:0]   fh_ff, fh_in;
   logic [15:0]   mf_ff, mf_in;
   logic [2:0]    pv_ff, pv_in;
   logic [3:0]    sub_ff, sub_in;

   logic          out_valid_ff, out_valid_in;
   logic [1:0]    out_status_ff, out_status_in;
   logic [31:0]   out_width_ff, out_width_in;
   logic [31:0]   out_height_ff, out_height_in;

   logic          step;
   logic [7:0]    b;
   logic          do_after, do_chunk, finish, finish_good;
   logic [15:0]   seg;
   logic [7:0]    mk, prec;
   logic [31:0]   size;
   logic [32:0]   three_b;
   logic [49:0]   area;
   logic [1:0]    st;

   function automatic logic edge_pass(input logic [31:0] v, input logic [31:0] lim);
      return (v != 32'h0) && (v <= lim);
   endfunction

   assign step = head_word.valid && (!head_word.last_byte || !out_valid_ff || out_ready);
   assign head_pop = step;
   assign b = head_word.data_byte;

   assign out_valid  = out_valid_ff;
   assign out_status = out_status_ff;
   assign out_width  = out_width_ff;
   assign out_height = out_height_ff;

   always_comb begin
      fmt_in = fmt_ff; ph_in = ph_ff; pos_in = pos_ff; span_in = span_ff;
      riff_in = riff_ff; crc_in = crc_ff; fs_in = fs_ff; fw_in = fw_ff; fh_in = fh_ff;
      mf_in = mf_ff; pv_in = pv_ff; sub_in = sub_ff;
      do_after = 1'b0; do_chunk = 1'b0; finish = 1'b0; finish_good = 1'b0;
      seg = '0; mk = mf_ff[7:0]; prec = mf_ff[15:8]; size = '0; area = '0; st = ihde_pkg::ST_UV;
      three_b = ({25'h0, b} << 1) + {25'h0, b};
      out_valid_in = out_valid_ff && !out_ready;
      out_status_in = out_status_ff; out_width_in = out_width_ff;
      out_height_in = out_height_ff;

      if (step) begin
         if (fmt_ff == ihde_pkg::FMT_WEBP && pos_ff >= PB'(8) && riff_ff != '0)
            riff_in = riff_ff - 1'b1;

         case (ph_ff)
            ihde_pkg::PH_HEAD: begin
               if (pos_ff == '0) begin
                  if (b == 8'h89) fmt_in = ihde_pkg::FMT_PNG;
                  else if (b == 8'hFF) fmt_in = ihde_pkg::FMT_JPEG;
                  else if (b == 8'h52) fmt_in = ihde_pkg::FMT_WEBP;
                  else begin pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE; end
               end else if (fmt_ff == ihde_pkg::FMT_PNG) begin
                  if (pos_ff < PB'(8)) begin
                     if (b != ihde_pkg::PNG_SIG[pos_ff[2:0]]) begin
                        pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE;
                     end
                  end else begin
                     if (pos_ff >= PB'(12) && pos_ff <= PB'(28))
                        crc_in = ihde_pkg::crc_step(crc_ff, b);
                     fs_in = {fs_ff[23:0], b};
                     if (pos_ff == PB'(11) && fs_in != 32'd13) begin
                        pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE;
                     end else if (pos_ff >= PB'(12) && pos_ff <= PB'(15)
                                  && b != ihde_pkg::IHDR_TAG[pos_ff[1:0]]) begin
                        pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE;
                     end else if (pos_ff == PB'(19)) begin
                        fw_in = fs_in;
                     end else if (pos_ff == PB'(23)) begin
                        fh_in = fs_in;
                     end else if (pos_ff == PB'(24)) begin
                        mf_in = {8'h0, b};
                     end else if (pos_ff == PB'(25) && !ihde_pkg::depth_fits(b, mf_ff[7:0])) begin
                        pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE;
                     end else if ((pos_ff == PB'(26) || pos_ff == PB'(27)) && b != 8'h0) begin
                        pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE;
                     end else if (pos_ff == PB'(28) && b > 8'd1) begin
                        pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE;
                     end else if (pos_ff == PB'(32)) begin
                        ph_in = ihde_pkg::PH_DONE;
                        if ((~crc_ff) == fs_in && edge_pass(fw_ff, max_edge_ff)
                            && edge_pass(fh_ff, max_edge_ff))
                           pv_in = {1'b0, ihde_pkg::ST_OK} + 3'd1;
                        else
                           pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1;
                     end
                  end
               end else if (fmt_ff == ihde_pkg::FMT_JPEG) begin
                  if (b == 8'hD8) ph_in = ihde_pkg::J_FF;
                  else begin pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE; end
               end else begin
                  if (pos_ff < PB'(4)) begin
                     if (b != ihde_pkg::RIFF_TAG[pos_ff[1:0]]) begin
                        pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE;
                     end
                  end else if (pos_ff < PB'(8)) begin
                     case (pos_ff[1:0])
                        2'd0: fs_in[7:0] = fs_ff[7:0] | b;
                        2'd1: fs_in[15:8] = fs_ff[15:8] | b;
                        2'd2: fs_in[23:16] = fs_ff[23:16] | b;
                        default: fs_in[31:24] = fs_ff[31:24] | b;
                     endcase
                     if (pos_ff == PB'(7)) begin
                        if (fs_in < 32'd4 || fs_in > 32'hFFFFFFF6 || fs_in[0]) begin
                           pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE;
                        end else begin
                           riff_in = {1'b0, fs_in};
                        end
                     end
                  end else if (b != ihde_pkg::WEBP_TAG[pos_ff[1:0]]) begin
                     pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE;
                  end else if (pos_ff == PB'(11)) begin
                     do_chunk = 1'b1;
                  end
               end
            end
            ihde_pkg::J_FF: begin
               if (b == 8'hFF) ph_in = ihde_pkg::J_MARK;
               else begin pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE; end
            end
            ihde_pkg::J_MARK: begin
               if (b == 8'hFF) begin
                  // fill byte
               end else if (b == 8'hD8 || b == 8'h01 || (b >= 8'hD0 && b <= 8'hD7)) begin
                  ph_in = ihde_pkg::J_FF;
               end else if (b == 8'h00 || b == 8'hD9 || b == 8'hDA) begin
                  pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE;
               end else begin
                  mf_in = {8'h0, b}; ph_in = ihde_pkg::J_LEN_HI;
               end
            end
            ihde_pkg::J_LEN_HI: begin
               fs_in = {24'h0, b}; ph_in = ihde_pkg::J_LEN_LO;
            end
            ihde_pkg::J_LEN_LO: begin
               seg = {fs_ff[7:0], b};
               if (seg < 16'd2) begin
                  pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE;
               end else begin
                  span_in = {17'h0, seg - 16'd2};
                  if (mk >= 8'hC0 && mk <= 8'hCF && mk != 8'hC4 && mk != 8'hC8 && mk != 8'hCC)
                  begin
                     if (!(mk inside {8'hC0, 8'hC1, 8'hC2, 8'hC9, 8'hCA})) begin
                        pv_in = {1'b0, ihde_pkg::ST_UNSUP} + 3'd1; ph_in = ihde_pkg::J_TAIL;
                     end else if (seg < 16'd8) begin
                        pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE;
                     end else begin
                        ph_in = ihde_pkg::J_FRAME; sub_in = '0;
                     end
                  end else begin
                     ph_in = (span_in != '0) ? ihde_pkg::J_SKIP : ihde_pkg::J_FF;
                  end
               end
            end
            ihde_pkg::J_SKIP: begin
               span_in = span_ff - 1'b1;
               if (span_in == '0) ph_in = ihde_pkg::J_FF;
            end
            ihde_pkg::J_FRAME: begin
               sub_in = sub_ff + 1'b1;
               span_in = span_ff - 1'b1;
               case (sub_ff)
                  4'd0: mf_in = {b, mf_ff[7:0]};
                  4'd1: fh_in = {16'h0, b, 8'h0};
                  4'd2: fh_in = fh_ff | {24'h0, b};
                  4'd3: fw_in = {16'h0, b, 8'h0};
                  4'd4: fw_in = fw_ff | {24'h0, b};
                  default: begin
                     if ((prec != 8'd8 && (mk == 8'hC0 || prec != 8'd12)) || b == 8'h0
                         || span_in != three_b || !edge_pass(fw_ff, max_edge_ff)
                         || !edge_pass(fh_ff, max_edge_ff)) begin
                        pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE;
                     end else begin
                        pv_in = {1'b0, ihde_pkg::ST_OK} + 3'd1; ph_in = ihde_pkg::J_TAIL;
                     end
                  end
               endcase
            end
            ihde_pkg::J_TAIL: begin
               if (span_ff != '0) span_in = span_ff - 1'b1;
            end
            ihde_pkg::W_HDR: begin
               sub_in = sub_ff + 1'b1;
               if (sub_ff < 4'd3) begin
                  if (b != ihde_pkg::VP8_TAG[sub_ff[1:0]]) mf_in = mf_ff | ihde_pkg::MISMATCH_FLAG;
               end else if (sub_ff == 4'd3) begin
                  mf_in = '0;
                  if ((mf_ff & ihde_pkg::MISMATCH_FLAG) == '0) begin
                     if (b == 8'h20) mf_in = {8'h0, ihde_pkg::KIND_VP8};
                     else if (b == 8'h4C) mf_in = {8'h0, ihde_pkg::KIND_VP8L};
                     else if (b == 8'h58) mf_in = {8'h0, ihde_pkg::KIND_VP8X};
                  end
               end else begin
                  case (sub_ff[1:0])
                     2'd0: fs_in[7:0] = fs_ff[7:0] | b;
                     2'd1: fs_in[15:8] = fs_ff[15:8] | b;
                     2'd2: fs_in[23:16] = fs_ff[23:16] | b;
                     default: fs_in[31:24] = fs_ff[31:24] | b;
                  endcase
                  if (sub_ff == 4'd7) begin
                     size = fs_in;
                     if ({1'b0, size} > riff_in || (size[0] && {1'b0, size} == riff_in)) begin
                        pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE;
                     end else begin
                        if (size[0]) mf_in = mf_ff | ihde_pkg::ODD_FLAG;
                        span_in = {1'b0, size};
                        sub_in = '0; fs_in = '0; fw_in = '0; fh_in = '0;
                        if (mk == ihde_pkg::KIND_NONE) begin
                           if (span_in != '0) ph_in = ihde_pkg::W_SKIP;
                           else do_after = 1'b1;
                        end else if ((mk == ihde_pkg::KIND_VP8 && size < 32'd10)
                                     || (mk == ihde_pkg::KIND_VP8L && size < 32'd5)
                                     || (mk == ihde_pkg::KIND_VP8X && size != 32'd10)) begin
                           pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE;
                        end else begin
                           ph_in = ihde_pkg::W_BODY;
                        end
                     end
                  end
               end
            end
            ihde_pkg::W_SKIP: begin
               span_in = span_ff - 1'b1;
               if (span_in == '0) do_after = 1'b1;
            end
            ihde_pkg::W_BODY: begin
               sub_in = sub_ff + 1'b1;
               span_in = span_ff - 1'b1;
               if (mk == ihde_pkg::KIND_VP8) begin
                  if ((sub_ff == 4'd0 && b[0]) || (sub_ff == 4'd3 && b != 8'h9D)
                      || (sub_ff == 4'd4 && b != 8'h01) || (sub_ff == 4'd5 && b != 8'h2A)) begin
                     pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE;
                  end else if (sub_ff == 4'd6) begin
                     fw_in = {24'h0, b};
                  end else if (sub_ff == 4'd7) begin
                     fw_in = {18'h0, b[5:0], fw_ff[7:0]};
                  end else if (sub_ff == 4'd8) begin
                     fh_in = {24'h0, b};
                  end else if (sub_ff == 4'd9) begin
                     fh_in = {18'h0, b[5:0], fh_ff[7:0]};
                     finish = 1'b1; finish_good = 1'b1;
                  end
               end else if (mk == ihde_pkg::KIND_VP8L) begin
                  if (sub_ff == 4'd0) begin
                     if (b != 8'h2F) begin
                        pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE;
                     end
                  end else begin
                     case (sub_ff)
                        4'd1: fs_in[7:0] = fs_ff[7:0] | b;
                        4'd2: fs_in[15:8] = fs_ff[15:8] | b;
                        4'd3: fs_in[23:16] = fs_ff[23:16] | b;
                        default: fs_in[31:24] = fs_ff[31:24] | b;
                     endcase
                     if (sub_ff == 4'd4) begin
                        fw_in = {18'h0, fs_in[13:0]} + 32'd1;
                        fh_in = {18'h0, fs_in[27:14]} + 32'd1;
                        finish = 1'b1; finish_good = (fs_in[31:29] == 3'd0);
                     end
                  end
               end else begin
                  case (sub_ff)
                     4'd4: fw_in[7:0] = fw_ff[7:0] | b;
                     4'd5: fw_in[15:8] = fw_ff[15:8] | b;
                     4'd6: fw_in[23:16] = fw_ff[23:16] | b;
                     4'd7: fh_in[7:0] = fh_ff[7:0] | b;
                     4'd8: fh_in[15:8] = fh_ff[15:8] | b;
                     4'd9: fh_in[23:16] = fh_ff[23:16] | b;
                     default: ;
                  endcase
                  if (sub_ff == 4'd9) begin
                     fw_in = fw_in + 32'd1;
                     fh_in = fh_in + 32'd1;
                     // both edges fit in 25 bits here
                     area = {25'h0, fw_in[24:0]} * {25'h0, fh_in[24:0]};
                     finish = 1'b1; finish_good = (area[49:32] == '0);
                  end
               end
               if (finish) begin
                  if (!finish_good || !edge_pass(fw_in, max_edge_ff)
                      || !edge_pass(fh_in, max_edge_ff)) begin
                     pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE;
                  end else begin
                     pv_in = {1'b0, ihde_pkg::ST_OK} + 3'd1;
                     if (span_in != '0) ph_in = ihde_pkg::W_SKIP;
                     else do_after = 1'b1;
                  end
               end
            end
            ihde_pkg::W_PAD: begin
               if (b != 8'h0) begin
                  pv_in = {1'b0, ihde_pkg::ST_UV} + 3'd1; ph_in = ihde_pkg::PH_DONE;
               end else if (pv_ff != '0) begin
                  ph_in = ihde_pkg::PH_DONE;
               end else begin
                  do_chunk = 1'b1;
               end
            end
            default: ;
         endcase

         if (do_after) begin
            if ((mf_in & ihde_pkg::ODD_FLAG) != '0) ph_in = ihde_pkg::W_PAD;
            else if (pv_in != '0) ph_in = ihde_pkg::PH_DONE;
            else do_chunk = 1'b1;
         end
         if (do_chunk) begin
            if (riff_in < 33'd8) begin
               pv_in = (riff_in == '0) ? {1'b0, ihde_pkg::ST_UNSUP} + 3'd1
                                        : {1'b0, ihde_pkg::ST_UV} + 3'd1;
               ph_in = ihde_pkg::PH_DONE;
            end else begin
               ph_in = ihde_pkg::W_HDR; sub_in = '0; mf_in = '0; fs_in = '0;
            end
         end

         if (pos_ff != '1) pos_in = pos_ff + 1'b1;

         if (head_word.last_byte) begin
            st = ihde_pkg::ST_UV;
            if (pv_in != '0 && pos_in >= PB'(12)) begin
               st = 2'(pv_in - 3'd1);
               if (ph_in == ihde_pkg::J_TAIL && span_in != '0) st = ihde_pkg::ST_UV;
               if (ph_in == ihde_pkg::W_SKIP || ph_in == ihde_pkg::W_PAD) st = ihde_pkg::ST_UV;
               if (fmt_in == ihde_pkg::FMT_WEBP && riff_in != '0) st = ihde_pkg::ST_UV;
               if (st > ihde_pkg::ST_UNSUP) st = ihde_pkg::ST_UV;
            end
            out_valid_in  = 1'b1;
            out_status_in = st;
            out_width_in  = (st == ihde_pkg::ST_OK) ? fw_in : 32'h0;
            out_height_in = (st == ihde_pkg::ST_OK) ? fh_in : 32'h0;
            fmt_in = ihde_pkg::FMT_NONE; ph_in = ihde_pkg::PH_HEAD; pos_in = '0;
            span_in = '0; riff_in = '0; crc_in = '1; fs_in = '0; fw_in = '0; fh_in = '0;
            mf_in = '0; pv_in = '0; sub_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_edge_ff <= ihde_pkg::MAX_EDGE_RESET;
         fmt_ff <= ihde_pkg::FMT_NONE; ph_ff <= ihde_pkg::PH_HEAD; pos_ff <= '0;
         span_ff <= '0; riff_ff <= '0; crc_ff <= '1; fs_ff <= '0; fw_ff <= '0; fh_ff <= '0;
         mf_ff <= '0; pv_ff <= '0; sub_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) max_edge_ff <= csr_write_data;
         fmt_ff <= fmt_in; ph_ff <= ph_in; pos_ff <= pos_in;
         span_ff <= span_in; riff_ff <= riff_in; crc_ff <= crc_in; fs_ff <= fs_in;
         fw_ff <= fw_in; fh_ff <= fh_in; mf_ff <= mf_in; pv_ff <= pv_in; sub_ff <= sub_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_width_ff  <= out_width_in;
      out_height_ff <= out_height_in;
   end

endmodule

// ----- src/ihde_checker.sv -----
`timescale 1ns / 1ps
module ihde_assert_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_img_width,
   input logic [31:0] rsp_img_height
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ihde_pkg::ST_OK |-> rsp_img_width == 32'h0
                                                   && rsp_img_height == 32'h0)
      else $error("nonzero size on a failed result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ihde_pkg::ST_OK |-> rsp_img_width != 32'h0
                                                  && rsp_img_height != 32'h0)
      else $error("zero edge on an ok result");

endmodule

bind image_header_dimension_extractor ihde_assert_checker u_ihde_assert_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_img_width  (rsp_chan.img_width),
   .rsp_img_height (rsp_chan.img_height)
);
